>>> hw/rtl/lpcp_pkg.sv
// Package: shared constants and types for the lidar point projection pipeline.
`timescale 1ns / 1ps
package lpcp_pkg;
    localparam int COLOR_STEPS_DEF = 256;
    localparam int QW = 20;            // quotient magnitude bits
    localparam int NUM_W = 62;         // xc*2^16 magnitude width

    typedef enum logic [1:0] {
        ST_INSIDE = 2'd0,
        ST_BEHIND = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CFG_ROT0 = 3'd0,
        CFG_ROT1 = 3'd1,
        CFG_ROT2 = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_FOCAL = 3'd4,
        CFG_CENTER = 3'd5,
        CFG_DIST = 3'd6,
        CFG_SIZE = 3'd7
    } cfg_idx_t;

    // Division lane payload: remainders, quotients, signs, the behind flag and zc
    typedef struct packed {
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [QW:0]      qx;
        logic [QW:0]      qy;
        logic             neg_x;
        logic             neg_y;
        logic             behind;
        logic [45:0]      zc;
    } div_lane_t;
endpackage

>>> hw/rtl/lpcp_transform.sv
// Camera-frame transform: rotation plus offset, two register stages.
`timescale 1ns / 1ps
module lpcp_transform
    import lpcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [23:0] px,
    input  logic signed [23:0] py,
    input  logic signed [23:0] pz,
    input  logic [47:0]        rot_row0,
    input  logic [47:0]        rot_row1,
    input  logic [47:0]        rot_row2,
    input  logic [62:0]        cam_offset,
    output logic               out_valid,
    output logic signed [45:0] xc,
    output logic signed [45:0] yc,
    output logic signed [45:0] zc
);
    logic signed [39:0] prod_reg [9];
    logic v1_reg;
    logic v2_reg;
    logic signed [45:0] xc_reg, yc_reg, zc_reg;
    logic signed [45:0] sx, sy, sz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= $signed(rot_row0[15:0]) * px;
            prod_reg[1] <= $signed(rot_row0[31:16]) * py;
            prod_reg[2] <= $signed(rot_row0[47:32]) * pz;
            prod_reg[3] <= $signed(rot_row1[15:0]) * px;
            prod_reg[4] <= $signed(rot_row1[31:16]) * py;
            prod_reg[5] <= $signed(rot_row1[47:32]) * pz;
            prod_reg[6] <= $signed(rot_row2[15:0]) * px;
            prod_reg[7] <= $signed(rot_row2[31:16]) * py;
            prod_reg[8] <= $signed(rot_row2[47:32]) * pz;
        end
    end

    always_comb
    begin
        sx = 46'(prod_reg[0]) + 46'(prod_reg[1]) + 46'(prod_reg[2])
           + {{11{cam_offset[20]}}, cam_offset[20:0], 14'd0} + 46'sd8192;
        sy = 46'(prod_reg[3]) + 46'(prod_reg[4]) + 46'(prod_reg[5])
           + {{11{cam_offset[41]}}, cam_offset[41:21], 14'd0} + 46'sd8192;
        sz = 46'(prod_reg[6]) + 46'(prod_reg[7]) + 46'(prod_reg[8])
           + {{11{cam_offset[62]}}, cam_offset[62:42], 14'd0} + 46'sd8192;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xc_reg <= sx >>> 14;
            yc_reg <= sy >>> 14;
            zc_reg <= sz >>> 14;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign xc = xc_reg;
    assign yc = yc_reg;
    assign zc = zc_reg;
endmodule

>>> hw/rtl/lpcp_divider.sv
// Pipelined restoring divider: one quotient bit per stage, both axes share the divisor.
`timescale 1ns / 1ps
module lpcp_divider
    import lpcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [45:0] xc,
    input  logic signed [45:0] yc,
    input  logic signed [45:0] zc,
    output logic               out_valid,
    output logic signed [20:0] xn,
    output logic signed [20:0] yn,
    output logic signed [45:0] zc_out,
    output logic               behind
);
    // quotient is clamped to 2^19, so QW+1 bits of quotient suffice once
    // the high part is checked: numerator >= zc*2^(QW+1) means saturate.
    localparam int STAGES = QW + 1;

    div_lane_t lane_reg [STAGES+1];
    logic [STAGES:0] v_reg;
    logic [44:0] dvs_reg [STAGES+1];
    logic sat_x_reg [STAGES+1];
    logic sat_y_reg [STAGES+1];

    logic [NUM_W-1:0] mag_x, mag_y;
    logic [44:0] dvs;

    always_comb
    begin
        mag_x = xc[45] ? NUM_W'(-{xc, 16'd0}) : NUM_W'({xc, 16'd0});
        mag_y = yc[45] ? NUM_W'(-{yc, 16'd0}) : NUM_W'({yc, 16'd0});
        dvs = zc[44:0];
    end

    // entry stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0].rem_x <= mag_x;
            lane_reg[0].rem_y <= mag_y;
            lane_reg[0].qx <= '0;
            lane_reg[0].qy <= '0;
            lane_reg[0].neg_x <= xc[45];
            lane_reg[0].neg_y <= yc[45];
            lane_reg[0].behind <= (zc[45] || zc == 46'sd0);
            lane_reg[0].zc <= zc;
            dvs_reg[0] <= dvs;
            sat_x_reg[0] <= ((mag_x >> STAGES) >= NUM_W'(dvs));
            sat_y_reg[0] <= ((mag_y >> STAGES) >= NUM_W'(dvs));
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int SH = STAGES - 1 - s;
        logic [NUM_W-1:0] tx, ty;
        logic gx, gy;
        always_comb
        begin
            tx = NUM_W'(dvs_reg[s]) << SH;
            ty = NUM_W'(dvs_reg[s]) << SH;
            gx = !sat_x_reg[s] && (lane_reg[s].rem_x >= tx);
            gy = !sat_y_reg[s] && (lane_reg[s].rem_y >= ty);
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[s+1].rem_x <= gx ? lane_reg[s].rem_x - tx : lane_reg[s].rem_x;
                lane_reg[s+1].rem_y <= gy ? lane_reg[s].rem_y - ty : lane_reg[s].rem_y;
                lane_reg[s+1].qx <= {lane_reg[s].qx[QW-1:0], gx};
                lane_reg[s+1].qy <= {lane_reg[s].qy[QW-1:0], gy};
                lane_reg[s+1].neg_x <= lane_reg[s].neg_x;
                lane_reg[s+1].neg_y <= lane_reg[s].neg_y;
                lane_reg[s+1].behind <= lane_reg[s].behind;
                lane_reg[s+1].zc <= lane_reg[s].zc;
                dvs_reg[s+1] <= dvs_reg[s];
                sat_x_reg[s+1] <= sat_x_reg[s];
                sat_y_reg[s+1] <= sat_y_reg[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[STAGES-1:0], in_valid};
        end
    end

    logic [QW:0] lim;
    logic [QW:0] mx, my;
    always_comb
    begin
        lim = (QW+1)'(1) << 19;
        mx = (sat_x_reg[STAGES] || lane_reg[STAGES].qx > lim) ? lim : lane_reg[STAGES].qx;
        my = (sat_y_reg[STAGES] || lane_reg[STAGES].qy > lim) ? lim : lane_reg[STAGES].qy;
    end

    assign out_valid = v_reg[STAGES];
    assign xn = lane_reg[STAGES].neg_x ? -$signed(mx) : $signed(mx);
    assign yn = lane_reg[STAGES].neg_y ? -$signed(my) : $signed(my);
    assign zc_out = lane_reg[STAGES].zc;
    assign behind = lane_reg[STAGES].behind;
endmodule

>>> hw/rtl/lpcp_distort.sv
// Distortion, focal scaling, bounds test and rainbow color, registered stages.
`timescale 1ns / 1ps
module lpcp_distort
    import lpcp_pkg::*;
#(
    parameter int COLOR_STEPS = COLOR_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [20:0] xn,
    input  logic signed [20:0] yn,
    input  logic signed [45:0] zc,
    input  logic               behind,
    input  logic [47:0]        focal_xy,
    input  logic [47:0]        center_xy,
    input  logic [59:0]        distortion,
    input  logic [31:0]        image_size,
    output logic               out_valid,
    output logic signed [19:0] pixel_u,
    output logic signed [19:0] pixel_v,
    output logic [22:0]        depth,
    output status_t            status,
    output logic [7:0]         color_blue,
    output logic [7:0]         color_green,
    output logic [7:0]         color_red
);
    localparam int NST = 7;

    logic [NST-1:0] v_reg;
    logic signed [20:0] xn_reg [NST];
    logic signed [20:0] yn_reg [NST];
    logic signed [45:0] zc_reg [NST];
    logic behind_reg [NST];

    logic signed [11:0] k1, k2, p1, p2, k3;
    assign k1 = distortion[11:0];
    assign k2 = distortion[23:12];
    assign p1 = distortion[35:24];
    assign p2 = distortion[47:36];
    assign k3 = distortion[59:48];

    // stage 0: squares
    logic signed [41:0] xx_p_reg, yy_p_reg, xy_p_reg;
    // stage 1: r2, xx, yy, xy
    logic signed [26:0] r2_reg, xx_reg, yy_reg, xy_reg;
    // stage 2: r4, tangential products
    logic signed [31:0] r4_reg;
    logic signed [26:0] r2b_reg;
    logic signed [40:0] dxa_reg, dxb_reg, dya_reg, dyb_reg;
    // stage 3: r6, tangential sums
    logic signed [38:0] r6_reg;
    logic signed [26:0] r2c_reg;
    logic signed [31:0] r4c_reg;
    logic signed [31:0] dx_reg, dy_reg;
    // stage 4: factor
    logic signed [40:0] fac_reg;
    logic signed [31:0] dx4_reg, dy4_reg;
    // stage 5: xd, yd
    logic signed [32:0] xd_reg, yd_reg;
    // stage 6: u, v
    logic signed [38:0] u_reg, v_out_reg;

    logic signed [53:0] r4f;
    logic signed [58:0] r6f;
    logic signed [50:0] facs;
    logic signed [61:0] xf, yf;
    logic signed [45:0] xds, yds;
    logic signed [59:0] uf, vf;

    always_comb
    begin
        r4f = 54'(r2_reg) * 54'(r2_reg);
        r6f = 59'(r4_reg) * 59'(r2b_reg);
        facs = 51'sd67108864 + 51'(k1) * 51'(r2c_reg) + 51'(k2) * 51'(r4c_reg)
             + 51'(k3) * 51'(r6_reg);
        xf = 62'(xn_reg[4]) * 62'(fac_reg);
        yf = 62'(yn_reg[4]) * 62'(fac_reg);
        xds = 46'(xf >>> 16) + 46'(dx4_reg);
        yds = 46'(yf >>> 16) + 46'(dy4_reg);
        uf = 60'(xd_reg) * $signed({36'd0, focal_xy[23:0]})
           + {{20{center_xy[23]}}, center_xy[23:0], 16'd0} + 60'sd524288;
        vf = 60'(yd_reg) * $signed({36'd0, focal_xy[47:24]})
           + {{20{center_xy[47]}}, center_xy[47:24], 16'd0} + 60'sd524288;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn_reg[0] <= xn;
            yn_reg[0] <= yn;
            zc_reg[0] <= zc;
            behind_reg[0] <= behind;
            for (int i = 1; i < NST; i++)
            begin
                xn_reg[i] <= xn_reg[i-1];
                yn_reg[i] <= yn_reg[i-1];
                zc_reg[i] <= zc_reg[i-1];
                behind_reg[i] <= behind_reg[i-1];
            end
            xx_p_reg <= xn * xn;
            yy_p_reg <= yn * yn;
            xy_p_reg <= xn * yn;
            r2_reg <= 27'((43'(xx_p_reg) + 43'(yy_p_reg)) >>> 16);
            xx_reg <= 27'(xx_p_reg >>> 16);
            yy_reg <= 27'(yy_p_reg >>> 16);
            xy_reg <= 27'(xy_p_reg >>> 16);
            r4_reg <= 32'(r4f >>> 16);
            r2b_reg <= r2_reg;
            dxa_reg <= 41'(p1) * 41'(xy_reg) * 41'sd2;
            dxb_reg <= 41'(p2) * (41'(r2_reg) + 41'(xx_reg) * 41'sd2);
            dya_reg <= 41'(p1) * (41'(r2_reg) + 41'(yy_reg) * 41'sd2);
            dyb_reg <= 41'(p2) * 41'(xy_reg) * 41'sd2;
            r6_reg <= 39'(r6f >>> 16);
            r2c_reg <= r2b_reg;
            r4c_reg <= r4_reg;
            dx_reg <= 32'((42'(dxa_reg) + 42'(dxb_reg)) >>> 10);
            dy_reg <= 32'((42'(dya_reg) + 42'(dyb_reg)) >>> 10);
            fac_reg <= 41'(facs >>> 10);
            dx4_reg <= dx_reg;
            dy4_reg <= dy_reg;
            xd_reg <= (xds > 46'sd2147483648) ? 33'sd2147483648 :
                      (xds < -46'sd2147483648) ? -33'sd2147483648 : 33'(xds);
            yd_reg <= (yds > 46'sd2147483648) ? 33'sd2147483648 :
                      (yds < -46'sd2147483648) ? -33'sd2147483648 : 33'(yds);
            u_reg <= 39'(uf >>> 20);
            v_out_reg <= 39'(vf >>> 20);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // output stage logic
    logic signed [45:0] zl;
    logic in_image;
    logic signed [50:0] z5;
    logic [7:0] idx;
    logic [10:0] jw;
    logic [10:0] j;
    logic [2:0] seg;
    logic [31:0] base;
    logic [31:0] pos;
    logic [7:0] up, dn;
    logic [21:0] wl, hl;

    always_comb
    begin
        zl = zc_reg[NST-1];
        wl = {image_size[15:0], 4'd0};
        hl = {image_size[31:16], 4'd0};
        in_image = !u_reg[38] && (u_reg < 39'($signed({1'b0, wl})))
                && !v_out_reg[38] && (v_out_reg < 39'($signed({1'b0, hl})));
        z5 = 51'(zl) * 5;
        if (z5 < 0)
            idx = 8'd0;
        else if ((z5 >>> 10) > 51'sd255)
            idx = 8'd255;
        else
            idx = 8'(z5 >>> 10);
        jw = 11'(idx) * 11'd5;
        j = (32'(jw) > 32'(5 * COLOR_STEPS - 1)) ? 11'(5 * COLOR_STEPS - 1) : jw;
        // ramp select by compare against ramp boundaries
        if (32'(j) >= 32'(4 * COLOR_STEPS))
        begin
            seg = 3'd4;
            base = 32'(4 * COLOR_STEPS);
        end
        else if (32'(j) >= 32'(3 * COLOR_STEPS))
        begin
            seg = 3'd3;
            base = 32'(3 * COLOR_STEPS);
        end
        else if (32'(j) >= 32'(2 * COLOR_STEPS))
        begin
            seg = 3'd2;
            base = 32'(2 * COLOR_STEPS);
        end
        else if (32'(j) >= 32'(COLOR_STEPS))
        begin
            seg = 3'd1;
            base = 32'(COLOR_STEPS);
        end
        else
        begin
            seg = 3'd0;
            base = '0;
        end
        pos = 32'(j) - base;
        up = (pos > 32'd255) ? 8'd255 : pos[7:0];
        dn = 8'd255 - up;
    end

    always_comb
    begin
        color_blue = '0;
        color_green = '0;
        color_red = '0;
        pixel_u = '0;
        pixel_v = '0;
        depth = '0;
        if (behind_reg[NST-1])
        begin
            status = ST_BEHIND;
        end
        else
        begin
            pixel_u = (u_reg > 39'sd524287) ? 20'sd524287 :
                      (u_reg < -39'sd524288) ? -20'sd524288 : 20'(u_reg);
            pixel_v = (v_out_reg > 39'sd524287) ? 20'sd524287 :
                      (v_out_reg < -39'sd524288) ? -20'sd524288 : 20'(v_out_reg);
            depth = (zl > 46'sd8388607) ? 23'd8388607 : 23'(zl);
            if (in_image)
            begin
                status = ST_INSIDE;
                case (seg)
                    3'd0: begin color_green = up; color_red = 8'd255; end
                    3'd1: begin color_green = 8'd255; color_red = dn; end
                    3'd2: begin color_blue = up; color_green = 8'd255; end
                    3'd3: begin color_blue = 8'd255; color_green = dn; end
                    default: begin color_blue = 8'd255; color_red = up; end
                endcase
            end
            else
            begin
                status = ST_OUTSIDE;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
endmodule

>>> hw/rtl/lidar_point_camera_projection.sv
// Top level: configuration registers, pipeline stall control and output register.
`timescale 1ns / 1ps
// Projects one lidar point per clock, unless stalled, into camera pixels. Each
// beat runs through a fixed pipeline: 2 stages of rotation and offset, 22 stages
// of a restoring divider (entry, then one quotient bit per stage), 7 stages of
// distortion, focal scaling and color, then an output register. The whole pipeline
// advances together; it halts only when the output register is full and stalled,
// so sustained throughput is one point per cycle. Configuration writes must
// happen with the pipeline empty. Status 1 marks points behind the camera.
module lidar_point_camera_projection
    import lpcp_pkg::*;
#(
    parameter int COLOR_STEPS = COLOR_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [62:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [19:0] pixel_u,
    output logic signed [19:0] pixel_v,
    output logic [22:0]        depth,
    output logic [1:0]         status,
    output logic [7:0]         color_blue,
    output logic [7:0]         color_green,
    output logic [7:0]         color_red
);
    logic [47:0] rot_row0_reg, rot_row1_reg, rot_row2_reg, focal_reg, center_reg;
    logic [62:0] offset_reg;
    logic [59:0] dist_reg;
    logic [31:0] size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row0_reg <= '0;
            rot_row1_reg <= '0;
            rot_row2_reg <= '0;
            offset_reg <= '0;
            focal_reg <= '0;
            center_reg <= '0;
            dist_reg <= '0;
            size_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROT0: rot_row0_reg <= cfg_data[47:0];
                CFG_ROT1: rot_row1_reg <= cfg_data[47:0];
                CFG_ROT2: rot_row2_reg <= cfg_data[47:0];
                CFG_OFFSET: offset_reg <= cfg_data;
                CFG_FOCAL: focal_reg <= cfg_data[47:0];
                CFG_CENTER: center_reg <= cfg_data[47:0];
                CFG_DIST: dist_reg <= cfg_data[59:0];
                CFG_SIZE: size_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the output register holds an untaken beat.
    logic en;
    logic oval_reg;
    assign en = !(oval_reg && out_stall);
    assign in_stall = !en;

    logic t_valid, d_valid, p_valid, behind;
    logic signed [45:0] xc, yc, zc, zc_d;
    logic signed [20:0] xn, yn;
    logic signed [19:0] pu, pv;
    logic [22:0] dep;
    status_t st;
    logic [7:0] cb, cg, cr;

    lpcp_transform u_xform (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .px(point_x), .py(point_y), .pz(point_z),
        .rot_row0(rot_row0_reg), .rot_row1(rot_row1_reg), .rot_row2(rot_row2_reg),
        .cam_offset(offset_reg),
        .out_valid(t_valid), .xc(xc), .yc(yc), .zc(zc)
    );

    lpcp_divider u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(t_valid),
        .xc(xc), .yc(yc), .zc(zc),
        .out_valid(d_valid), .xn(xn), .yn(yn), .zc_out(zc_d), .behind(behind)
    );

    lpcp_distort #(.COLOR_STEPS(COLOR_STEPS)) u_dist (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid),
        .xn(xn), .yn(yn), .zc(zc_d), .behind(behind),
        .focal_xy(focal_reg), .center_xy(center_reg),
        .distortion(dist_reg), .image_size(size_reg),
        .out_valid(p_valid), .pixel_u(pu), .pixel_v(pv), .depth(dep),
        .status(st), .color_blue(cb), .color_green(cg), .color_red(cr)
    );

    // Output register
    logic signed [19:0] pu_reg, pv_reg;
    logic [22:0] dep_reg;
    logic [1:0] st_reg;
    logic [7:0] cb_reg, cg_reg, cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oval_reg <= 1'b0;
        else if (en)
            oval_reg <= p_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg <= pu;
            pv_reg <= pv;
            dep_reg <= dep;
            st_reg <= st;
            cb_reg <= cb;
            cg_reg <= cg;
            cr_reg <= cr;
        end
    end

    assign out_valid = oval_reg;
    assign pixel_u = pu_reg;
    assign pixel_v = pv_reg;
    assign depth = dep_reg;
    assign status = st_reg;
    assign color_blue = cb_reg;
    assign color_green = cg_reg;
    assign color_red = cr_reg;

`ifndef SYNTHESIS
    // A stalled result beat must stay valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result beat dropped under stall");
    // Input is refused only when the output register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");
    // Behind-camera results carry zero depth and a zero red channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_BEHIND) |-> (depth == 23'd0 && color_red == 8'd0))
        else $error("behind-camera beat not cleared");
`endif
endmodule

>>> tb/tb_lidar_point_camera_projection.sv
// Testbench for the lidar point to camera pixel projection pipeline.
`timescale 1ns / 1ps
module tb_lidar_point_camera_projection;
    import lpcp_pkg::*;

    localparam int CLK_NS = 12;
    localparam int DRAIN = 40;          // a bit over the pipeline depth
    localparam int LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int BEATS_PER_PHASE = 105;
    localparam int NUM_PHASES = 10;
    localparam longint M = 1024;        // one metre in Q13.10

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [62:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [19:0] pixel_u;
    logic signed [19:0] pixel_v;
    logic [22:0]        depth;
    logic [1:0]         status;
    logic [7:0]         color_blue;
    logic [7:0]         color_green;
    logic [7:0]         color_red;

    lidar_point_camera_projection dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_u    (pixel_u),
        .pixel_v    (pixel_v),
        .depth      (depth),
        .status     (status),
        .color_blue (color_blue),
        .color_green(color_green),
        .color_red  (color_red)
    );

    // One projected pixel as the block should present it
    typedef struct {
        logic [19:0] u;
        logic [19:0] v;
        logic [22:0] dep;
        status_t     st;
        logic [7:0]  b;
        logic [7:0]  g;
        logic [7:0]  r;
    } pixel_t;

    class projection_scoreboard;
        logic [62:0] regs [8];
        pixel_t      pending [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
        endfunction

        static function longint clampl(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Rotate one axis and add its offset; rounds to Q.10
        function longint cam_axis(int k, longint px, longint py, longint pz);
            logic [47:0] row;
            logic [20:0] off;
            longint acc;
            row = regs[k][47:0];
            off = regs[CFG_OFFSET][21*k +: 21];
            acc = longint'($signed(row[15:0])) * px + longint'($signed(row[31:16])) * py
                + longint'($signed(row[47:32])) * pz + longint'($signed(off)) * 16384;
            return (acc + 8192) >>> 14;
        endfunction

        // Accepted input beat: work out the pixel it must produce
        function void note(logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z);
            longint px, py, pz, xc, yc, zc, xn, yn, r2, r4, r6, fac, xy, xx, yy;
            longint dx, dy, xd, yd, u, v, k1, k2, p1, p2, k3, fx, fy, cx, cy, w, h;
            longint idx, j, up;
            logic [59:0] dist_v;
            pixel_t e;
            px = x;
            py = y;
            pz = z;
            xc = cam_axis(0, px, py, pz);
            yc = cam_axis(1, px, py, pz);
            zc = cam_axis(2, px, py, pz);
            e = '{u: '0, v: '0, dep: '0, st: ST_BEHIND, b: '0, g: '0, r: '0};
            if (zc > 0) begin
                xn = clampl((xc * 65536) / zc, -(64'sd1 << 19), 64'sd1 << 19);
                yn = clampl((yc * 65536) / zc, -(64'sd1 << 19), 64'sd1 << 19);
                dist_v = regs[CFG_DIST][59:0];
                k1 = longint'($signed(dist_v[11:0]));
                k2 = longint'($signed(dist_v[23:12]));
                p1 = longint'($signed(dist_v[35:24]));
                p2 = longint'($signed(dist_v[47:36]));
                k3 = longint'($signed(dist_v[59:48]));
                r2 = (xn * xn + yn * yn) >>> 16;
                r4 = (r2 * r2) >>> 16;
                r6 = (r4 * r2) >>> 16;
                fac = ((64'sd1 << 26) + k1 * r2 + k2 * r4 + k3 * r6) >>> 10;
                xy = (xn * yn) >>> 16;
                xx = (xn * xn) >>> 16;
                yy = (yn * yn) >>> 16;
                dx = (2 * p1 * xy + p2 * (r2 + 2 * xx)) >>> 10;
                dy = (p1 * (r2 + 2 * yy) + 2 * p2 * xy) >>> 10;
                xd = clampl(((xn * fac) >>> 16) + dx, -(64'sd1 << 31), 64'sd1 << 31);
                yd = clampl(((yn * fac) >>> 16) + dy, -(64'sd1 << 31), 64'sd1 << 31);
                fx = longint'(regs[CFG_FOCAL][23:0]);
                fy = longint'(regs[CFG_FOCAL][47:24]);
                cx = longint'($signed(regs[CFG_CENTER][23:0]));
                cy = longint'($signed(regs[CFG_CENTER][47:24]));
                u = (xd * fx + cx * 65536 + (64'sd1 << 19)) >>> 20;
                v = (yd * fy + cy * 65536 + (64'sd1 << 19)) >>> 20;
                w = longint'(regs[CFG_SIZE][15:0]) * 16;
                h = longint'(regs[CFG_SIZE][31:16]) * 16;
                e.u = 20'(clampl(u, -524288, 524287));
                e.v = 20'(clampl(v, -524288, 524287));
                e.dep = 23'(clampl(zc, 0, 8388607));
                if (u >= 0 && u < w && v >= 0 && v < h) begin
                    e.st = ST_INSIDE;
                    // rainbow: five ramps of 256 steps, index stepped by five
                    idx = clampl((zc * 5) >>> 10, 0, 255);
                    j = clampl(idx * 5, 0, 5 * COLOR_STEPS_DEF - 1);
                    up = clampl(j % COLOR_STEPS_DEF, 0, 255);
                    case (j / COLOR_STEPS_DEF)
                        0: begin e.b = 0; e.g = 8'(up); e.r = 255; end
                        1: begin e.b = 0; e.g = 255; e.r = 8'(255 - up); end
                        2: begin e.b = 8'(up); e.g = 255; e.r = 0; end
                        3: begin e.b = 255; e.g = 8'(255 - up); e.r = 0; end
                        default: begin e.b = 255; e.g = 0; e.r = 8'(up); end
                    endcase
                end
                else begin
                    e.st = ST_OUTSIDE;
                end
            end
            pending = {pending, e};
        endfunction

        function void fail(string field, longint exp_v, longint act_v);
            $error("%s: expected %0d, got %0d", field, exp_v, act_v);
            errors++;
        endfunction

        // Accepted result beat: compare with the oldest pending pixel
        function void check(logic [19:0] u, logic [19:0] v, logic [22:0] dep,
                            logic [1:0] st, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            pixel_t e;
            if (pending.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (u !== e.u) fail("pixel_u", $signed(e.u), $signed(u));
            if (v !== e.v) fail("pixel_v", $signed(e.v), $signed(v));
            if (dep !== e.dep) fail("depth", e.dep, dep);
            if (st !== e.st) fail("status", e.st, st);
            if (b !== e.b) fail("color_blue", e.b, b);
            if (g !== e.g) fail("color_green", e.g, g);
            if (r !== e.r) fail("color_red", e.r, r);
        endfunction
    endclass

    projection_scoreboard sb;
    logic in_took;          // set when the previous rising edge accepted an input beat
    int   idle_pct;
    int   stall_pct;
    int   hold_left;        // long receiver hold-off, counted down by the receiver
    int   cycles;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_NS / 2) clk = ~clk;
    end

    // Both handshakes are sampled at the rising edge, before any register moves
    always @(posedge clk)
    begin
        in_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            sb.note(point_x, point_y, point_z);
        if (rst_n && out_valid && !out_stall)
            sb.check(pixel_u, pixel_v, depth, status, color_blue, color_green, color_red);
    end

    // Receiver: random stall per cycle, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint rnd_s(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    // Config writes happen on the falling edge with the pipeline empty
    task automatic write_reg(cfg_idx_t idx, logic [62:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.regs[idx] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_point(longint x, longint y, longint z);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        point_x  <= 24'(x);
        point_y  <= 24'(y);
        point_z  <= 24'(z);
        @(negedge clk);
        while (!in_took)
            @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Camera looks down lidar +x: xc = -y, yc = -z, zc = x (entries Q1.14)
    task automatic load_camera(logic [59:0] dist_coef, logic [31:0] size);
        write_reg(CFG_ROT0, 63'({16'h0000, 16'hC000, 16'h0000}));
        write_reg(CFG_ROT1, 63'({16'hC000, 16'h0000, 16'h0000}));
        write_reg(CFG_ROT2, 63'({16'h0000, 16'h0000, 16'h4000}));
        write_reg(CFG_OFFSET, {21'($urandom_range(0, 200)), 21'($urandom_range(0, 200)),
                               21'($urandom_range(0, 200))});
        write_reg(CFG_FOCAL, 63'({24'(500 * 256), 24'(520 * 256)}));
        write_reg(CFG_CENTER, 63'({24'(240 * 256), 24'(320 * 256)}));
        write_reg(CFG_DIST, 63'(dist_coef));
        write_reg(CFG_SIZE, 63'(size));
    endtask

    // Small random distortion, Q1.10 entries of a tenth or so
    function automatic logic [59:0] mild_distortion();
        logic [59:0] d;
        for (int i = 0; i < 5; i++)
            d[12*i +: 12] = 12'(rnd_s(-120, 120));
        return d;
    endfunction

    task automatic setup_phase(int kind);
        logic [62:0] rv;
        case (kind)
            0: load_camera('0, {16'd480, 16'd640});
            1: load_camera(mild_distortion(), {16'd480, 16'd640});
            2:
            begin
                // fully random register contents
                for (int i = 0; i < 8; i++)
                begin
                    rv = 63'({$urandom(), $urandom()});
                    write_reg(cfg_idx_t'(i), rv);
                end
            end
            3:
            begin
                // extremes: full-scale rotation, offset, focal, center, distortion
                write_reg(CFG_ROT0, 63'({16'h8000, 16'h7FFF, 16'h8000}));
                write_reg(CFG_ROT1, 63'({16'h7FFF, 16'h8000, 16'h7FFF}));
                write_reg(CFG_ROT2, 63'({16'h7FFF, 16'h7FFF, 16'h7FFF}));
                write_reg(CFG_OFFSET, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
                write_reg(CFG_FOCAL, 63'({24'hFFFFFF, 24'hFFFFFF}));
                write_reg(CFG_CENTER, 63'({24'h800000, 24'h7FFFFF}));
                write_reg(CFG_DIST, 63'({12'h7FF, 12'h800, 12'h7FF, 12'h800, 12'h7FF}));
                write_reg(CFG_SIZE, 63'(32'hFFFF_FFFF));
            end
            default:
            begin
                // zero width: nothing can land in the image
                load_camera(mild_distortion(), {16'd480, 16'd0});
            end
        endcase
    endtask

    // Mostly points in front of the camera, some noise over the full field range
    task automatic random_point();
        longint x;
        if ($urandom_range(0, 99) < 75)
        begin
            x = rnd_s(M / 4, 80 * M);
            send_point(x, rnd_s(-x, x), rnd_s(-x, x));
        end
        else
        begin
            send_point(rnd_s(-8388608, 8388607), rnd_s(-8388608, 8388607),
                       rnd_s(-8388608, 8388607));
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        point_x   = '0;
        point_y   = '0;
        point_z   = '0;
        out_stall = 1'b0;
        in_took   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 0;
        cycles    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // registers at reset: every point has zero depth, so behind camera
        send_point(5 * M, M, -M);
        send_point(8388607, -8388608, 8388607);
        drain();

        load_camera('0, {16'd480, 16'd640});
        send_point(10 * M, 0, 0);                  // optical axis, center pixel
        send_point(-5 * M, 0, 0);                  // behind camera
        send_point(0, 3 * M, M);                   // x = 0: depth from the offset only
        send_point(20 * M, 3 * M, -2 * M);         // in the image, near
        send_point(60 * M, 0, 0);                  // far: color index clamps
        send_point(M, 50 * M, -50 * M);            // large angle, saturates
        send_point(5 * M, -20 * M, 0);             // outside image
        send_point(8388607, 0, 0);
        send_point(-8388608, -8388608, -8388608);
        send_point(8388607, 8388607, 8388607);
        send_point(M, -8388608, 8388607);
        send_point(M, 8388607, -8388608);
        for (int i = 1; i <= 8; i++)
            send_point(i * 7 * M / 4, M / 2, -M / 3);  // sweep the first two color ramps
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            setup_phase(ph % 5);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                // long receiver hold-off while points keep coming
                if (ph == 0 && n == 10)
                    hold_left = HOLD_CYCLES;
                // sender pauses until every pending pixel is out
                if (ph == 1 && n == 50)
                    while (sb.pending.size() != 0)
                    begin
                        in_valid <= 1'b0;
                        @(negedge clk);
                    end
                random_point();
            end
            drain();
        end

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/lpcp_pkg.sv
hw/rtl/lpcp_transform.sv
hw/rtl/lpcp_divider.sv
hw/rtl/lpcp_distort.sv
hw/rtl/lidar_point_camera_projection.sv
tb/tb_lidar_point_camera_projection.sv
